### design/rsa_pkg.sv
// ----------------------------------------------------------------------------
// Reservation slot allocator package
// Widths, codes and reset values that the channel interfaces and the core use.
// ----------------------------------------------------------------------------
package rsa_pkg;

  // Default sizing of the slot tables.
  localparam int SLOTS_DEF = 16;
  localparam int TASKS_DEF = 8;

  // Field widths.
  localparam int CMD_W   = 2;
  localparam int TASK_W  = 3;
  localparam int SIZE_W  = 23;
  localparam int ADDR_W  = 32;
  localparam int STAT_W  = 3;
  localparam int CNT_W   = 5;
  localparam int SST_W   = 2;
  localparam int CIDX_W  = 1;
  localparam int CDATA_W = 32;

  // Reset values of the configuration registers.
  localparam logic [SIZE_W-1:0] LIMIT_RST = SIZE_W'(4194304);
  localparam logic [ADDR_W-1:0] BASE_RST  = 32'hA10C_0000;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] REG_LIMIT = 1'b0;
  localparam logic [CIDX_W-1:0] REG_BASE  = 1'b1;

  // Commands.
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_KILL  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SWEEP = 2'd3;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STAT_W-1:0] STAT_OVER     = 3'd1;
  localparam logic [STAT_W-1:0] STAT_NO_SLOT  = 3'd2;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd3;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd4;

  // Slot states.
  localparam logic [SST_W-1:0] SL_FREE     = 2'd0;
  localparam logic [SST_W-1:0] SL_ACTIVE   = 2'd1;
  localparam logic [SST_W-1:0] SL_PENDING  = 2'd2;
  localparam logic [SST_W-1:0] SL_RELEASED = 2'd3;

endpackage

### design/rsa_ifs.sv
// ----------------------------------------------------------------------------
// Reservation slot allocator channels
// Valid/ready interfaces for the command, result and configuration channels.
// ----------------------------------------------------------------------------

// Command channel.
interface rsa_in_if import rsa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [TASK_W-1:0] task_req;
  logic [SIZE_W-1:0] req_size;
  logic [ADDR_W-1:0] req_addr;

  modport source (output valid, cmd, task_req, req_size, req_addr, input ready);
  modport sink   (input valid, cmd, task_req, req_size, req_addr, output ready);
endinterface

// Result channel.
interface rsa_out_if import rsa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ADDR_W-1:0] block_addr;
  logic [SIZE_W-1:0] block_size;
  logic [CNT_W-1:0]  active_count;
  logic              last;

  modport source (output valid, status, block_addr, block_size, active_count, last,
                  input ready);
  modport sink   (input valid, status, block_addr, block_size, active_count, last,
                  output ready);
endinterface

// Configuration write channel.
interface rsa_cfg_if import rsa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CIDX_W-1:0]  index;
  logic [CDATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### design/reservation_slot_allocator_core.sv
// ----------------------------------------------------------------------------
// Reservation slot allocator core
// Per-task slot tables with alloc, free, kill and sweep, scanned by one
// shared slot evaluator under a small sequencer.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Beat contents
//  --------+-----------+---------------------------------------------------
//  in_ch   | sink      | cmd, task_req, req_size, req_addr
//  out_ch  | source    | status, block_addr, block_size, active_count, last
//  cfg_ch  | sink      | index (0 byte limit, 1 region base), data
//
//  Alloc and free stop the scan at the first hit; an alloc over the limit is
//  answered from the start state without a scan, and sweep ends with a final
//  beat from the flush state. The scan reads one slot of the slot memories per
//  cycle unless the result register stalls it. After reset a clearing pass marks
//  every slot free; no command is taken meanwhile, configuration writes are.
//  A stalled result register holds the scan on the slot that must report.
//
module reservation_slot_allocator_core import rsa_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF,
  parameter int TASKS = TASKS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  rsa_in_if.sink    in_ch,
  rsa_out_if.source out_ch,
  rsa_cfg_if.sink   cfg_ch
);

  localparam int DEPTH = SLOTS * TASKS;
  localparam int MIW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SIW   = $clog2(SLOTS + 1);
  localparam int TIW   = (TASKS > 1) ? $clog2(TASKS) : 1;

  // Sequencer states.
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  // Task number reduced modulo TASKS by repeated subtraction.
  function automatic logic [TIW-1:0] task_mod(input logic [TASK_W-1:0] t);
    logic [TASK_W:0] v;
    v = {1'b0, t};
    for (int k = 0; k < 8; k++) begin
      if (int'(v) >= TASKS) v = v - (TASK_W + 1)'(TASKS);
    end
    return TIW'(v);
  endfunction

  // Slot memories.
  logic [SST_W-1:0]  st_mem   [DEPTH];
  logic [ADDR_W-1:0] addr_mem [DEPTH];
  logic [SIZE_W-1:0] size_mem [DEPTH];

  // Per-task counters.
  logic [SIZE_W-1:0] used_r [TASKS];
  logic [ADDR_W-1:0] next_r [TASKS];
  logic [CNT_W-1:0]  act_r  [TASKS];

  logic [2:0]        state_r, state_nxt;
  logic [MIW-1:0]    clr_idx_r, clr_idx_nxt;
  logic [SIW-1:0]    idx_r, idx_nxt;
  logic [SIZE_W-1:0] limit_r;
  logic [CMD_W-1:0]  cmd_r;
  logic [TIW-1:0]    task_r;
  logic [SIZE_W-1:0] size_r;
  logic [ADDR_W-1:0] addr_r;
  logic [MIW-1:0]    base_r;
  logic              held_v_r, held_v_nxt;
  logic [ADDR_W-1:0] held_addr_r;
  logic [SIZE_W-1:0] held_size_r;

  logic [SST_W-1:0]  st_q_r;
  logic [ADDR_W-1:0] addr_q_r;
  logic [SIZE_W-1:0] size_q_r;

  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [SIZE_W-1:0] out_size_r;
  logic [CNT_W-1:0]  out_count_r;
  logic              out_last_r;

  logic              in_acc, out_free, out_load;
  logic [TIW-1:0]    in_task;
  logic              emit, hit, done, stall, go, last_slot, over;
  logic [STAT_W-1:0] em_status;
  logic [ADDR_W-1:0] em_addr;
  logic [SIZE_W-1:0] em_size;
  logic [CNT_W-1:0]  em_count;
  logic              em_last;
  logic              st_we, ad_we, cnt_we;
  logic [SST_W-1:0]  st_wd;
  logic [MIW-1:0]    wr_addr, rd_addr, cur_addr;
  logic [SIZE_W:0]   sum_used;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign in_task  = task_mod(in_ch.task_req);
  assign out_free = !out_valid_r || out_ch.ready;
  assign out_load = emit && out_free;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign cur_addr  = base_r + MIW'(idx_r);
  assign last_slot = (idx_r == SIW'(SLOTS - 1));
  assign sum_used  = {1'b0, used_r[task_r]} + {1'b0, size_r};
  assign over      = (cmd_r == CMD_ALLOC) && (sum_used > {1'b0, limit_r});

  // Shared slot evaluator and sequencer.
  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    idx_nxt     = idx_r;
    held_v_nxt  = held_v_r;
    emit        = 1'b0;
    hit         = 1'b0;
    done        = 1'b0;
    em_status   = STAT_OK;
    em_addr     = '0;
    em_size     = '0;
    em_count    = act_r[task_r];
    em_last     = 1'b1;
    st_we       = 1'b0;
    ad_we       = 1'b0;
    cnt_we      = 1'b0;
    st_wd       = SL_FREE;
    wr_addr     = cur_addr;
    rd_addr     = base_r;
    stall       = 1'b0;
    go          = 1'b0;
    case (state_r)
      S_CLEAR: begin
        st_we       = 1'b1;
        wr_addr     = clr_idx_r;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == MIW'(DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) state_nxt = S_START;
      end
      S_START: begin
        // Limit check comes before the slot scan.
        if (over) begin
          emit      = 1'b1;
          em_status = STAT_OVER;
          if (out_free) state_nxt = S_IDLE;
        end else begin
          idx_nxt    = '0;
          held_v_nxt = 1'b0;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        case (cmd_r)
          CMD_ALLOC: begin
            hit   = (st_q_r == SL_FREE);
            emit  = hit || last_slot;
            done  = emit;
            st_wd = SL_ACTIVE;
            if (hit) begin
              em_addr  = next_r[task_r];
              em_count = act_r[task_r] + 1'b1;
            end else begin
              em_status = STAT_NO_SLOT;
            end
          end
          CMD_FREE: begin
            hit   = (st_q_r == SL_ACTIVE) && (addr_q_r == addr_r);
            emit  = hit || last_slot;
            done  = emit;
            st_wd = SL_PENDING;
            if (hit) em_count = act_r[task_r] - 1'b1;
            else     em_status = STAT_NOTFOUND;
          end
          CMD_KILL: begin
            hit   = (st_q_r == SL_ACTIVE);
            emit  = last_slot;
            done  = last_slot;
            st_wd = SL_PENDING;
          end
          default: begin
            // Sweep reports the previous pending slot once another is found.
            hit     = (st_q_r == SL_PENDING);
            emit    = hit && held_v_r;
            done    = last_slot;
            st_wd   = SL_RELEASED;
            em_addr = held_addr_r;
            em_size = held_size_r;
            em_last = 1'b0;
          end
        endcase
        stall = emit && !out_free;
        go    = !stall;
        st_we = go && hit;
        ad_we = go && hit && (cmd_r == CMD_ALLOC);
        cnt_we = go && hit && ((cmd_r == CMD_ALLOC) || (cmd_r == CMD_FREE));
        rd_addr = (go && !done) ? cur_addr + 1'b1 : cur_addr;
        if (go) begin
          idx_nxt = idx_r + 1'b1;
          if (hit && (cmd_r == CMD_SWEEP)) held_v_nxt = 1'b1;
          if (done) state_nxt = (cmd_r == CMD_SWEEP) ? S_FLUSH : S_IDLE;
        end
      end
      S_FLUSH: begin
        // Final sweep beat: the last released slot, or an empty report.
        emit = 1'b1;
        if (held_v_r) begin
          em_addr = held_addr_r;
          em_size = held_size_r;
        end else begin
          em_status = STAT_EMPTY;
        end
        if (out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      idx_r       <= '0;
      held_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      idx_r       <= idx_nxt;
      held_v_r    <= held_v_nxt;
      if (out_load)          out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // Command capture, sweep holding register and result register.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r  <= in_ch.cmd;
      task_r <= in_task;
      size_r <= in_ch.req_size;
      addr_r <= in_ch.req_addr;
      base_r <= MIW'(int'(in_task) * SLOTS);
    end
    if ((state_r == S_SCAN) && go && hit) begin
      held_addr_r <= addr_q_r;
      held_size_r <= size_q_r;
    end
    if (out_load) begin
      out_status_r <= em_status;
      out_addr_r   <= em_addr;
      out_size_r   <= em_size;
      out_count_r  <= em_count;
      out_last_r   <= em_last;
    end
  end

  // Slot memories: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (st_we) st_mem[wr_addr] <= st_wd;
    if (ad_we) begin
      addr_mem[wr_addr] <= next_r[task_r];
      size_mem[wr_addr] <= size_r;
    end
    st_q_r   <= st_mem[rd_addr];
    addr_q_r <= addr_mem[rd_addr];
    size_q_r <= size_mem[rd_addr];
  end

  // Configuration registers and per-task counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RST;
      for (int t = 0; t < TASKS; t++) begin
        used_r[t] <= '0;
        next_r[t] <= BASE_RST;
        act_r[t]  <= '0;
      end
    end else begin
      if (cnt_we) begin
        if (cmd_r == CMD_ALLOC) begin
          used_r[task_r] <= sum_used[SIZE_W-1:0];
          next_r[task_r] <= next_r[task_r] + ADDR_W'(size_r);
          act_r[task_r]  <= act_r[task_r] + 1'b1;
        end else begin
          used_r[task_r] <= used_r[task_r] - size_q_r;
          act_r[task_r]  <= act_r[task_r] - 1'b1;
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_LIMIT: limit_r <= cfg_ch.data[SIZE_W-1:0];
          REG_BASE: begin
            for (int t = 0; t < TASKS; t++) next_r[t] <= cfg_ch.data[ADDR_W-1:0];
          end
          default: begin
            limit_r <= limit_r;
          end
        endcase
      end
    end
  end

  // Result channel outputs.
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.block_addr   = out_addr_r;
  assign out_ch.block_size   = out_size_r;
  assign out_ch.active_count = out_count_r;
  assign out_ch.last         = out_last_r;

  // A taken command always enters the start state, where an alloc is checked against the limit.
  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_START)
    else $error("accepted command did not enter the start state");

  // No slot is rewritten while the scan waits on the result register.
  a_no_write_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && stall) |-> !st_we)
    else $error("slot written during a result stall");

  // The scan index stays within the task's table.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> idx_r < SIW'(SLOTS))
    else $error("scan index beyond the slot table");

  // Only a sweep reports that nothing was swept.
  a_empty_is_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && em_status == STAT_EMPTY) |-> cmd_r == CMD_SWEEP)
    else $error("empty-sweep status on another command");

  // The final beat of a command returns the sequencer to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && em_last) |=> state_r == S_IDLE)
    else $error("sequencer busy after the final beat");

endmodule

### tb/tb_reservation_slot_allocator_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Reservation slot allocator core testbench
// Drives alloc, free, kill and sweep commands through the command channel and
// checks every result beat against a shadow copy of the per-task slot tables.
// The limit and region base are rewritten between phases, with no command
// outstanding. Both channel sides insert random gaps, with bursts of
// back-to-back beats.
// ----------------------------------------------------------------------------
module tb_reservation_slot_allocator_core import rsa_pkg::*; ();

  localparam int SLOTS      = SLOTS_DEF;
  localparam int TASKS      = TASKS_DEF;
  localparam int MAX_GAP    = 18;
  localparam int IDLE_LIMIT = 2000;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [TASK_W-1:0] task_id;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
  } cmd_beat_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
    logic [CNT_W-1:0]  count;
    logic              last;
  } result_beat_t;

  logic clk;
  logic rst_n;

  rsa_in_if  in_ch ();
  rsa_out_if out_ch ();
  rsa_cfg_if cfg_ch ();

  reservation_slot_allocator_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Shadow copy of the configuration and of the per-task slot tables.
  logic [SIZE_W-1:0] limit_q;
  logic [ADDR_W-1:0] slot_addr_q  [TASKS*SLOTS];
  logic [SIZE_W-1:0] slot_size_q  [TASKS*SLOTS];
  logic [SST_W-1:0]  slot_state_q [TASKS*SLOTS];
  logic [SIZE_W-1:0] used_bytes_q [TASKS];
  logic [ADDR_W-1:0] next_addr_q  [TASKS];
  logic [CNT_W-1:0]  active_q     [TASKS];

  cmd_beat_t    pending_cmds[$];
  result_beat_t expected_results[$];

  // Bookkeeping.
  bit        in_fired;
  bit        out_fired;
  int        send_gap;
  bit        send_burst;
  int        recv_wait;
  bit        recv_burst;
  int        idle_cycles;
  int        mismatches;
  int        cmd_count;
  int        result_count;
  int        cfg_count;
  int        status_hits [8];
  cmd_beat_t drv_beat;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Works out the result beats of one accepted command and updates the shadow.
  task automatic predict_command(input cmd_beat_t c);
    int           t;
    int           base;
    int           n_pending;
    int           k;
    bit           hit;
    logic [SIZE_W:0] need;
    result_beat_t r;
    t    = int'(c.task_id) % TASKS;
    base = t * SLOTS;
    hit  = 1'b0;
    r    = '0;
    r.last = 1'b1;
    case (c.cmd)
      CMD_ALLOC: begin
        // The limit is checked before any slot is looked for.
        need = {1'b0, used_bytes_q[t]} + {1'b0, c.size};
        if (need > {1'b0, limit_q}) begin
          r.status = STAT_OVER;
        end else begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!hit && slot_state_q[base+i] == SL_FREE) begin
              hit = 1'b1;
              slot_addr_q[base+i]  = next_addr_q[t];
              slot_size_q[base+i]  = c.size;
              slot_state_q[base+i] = SL_ACTIVE;
              r.addr         = next_addr_q[t];
              next_addr_q[t] = next_addr_q[t] + ADDR_W'(c.size);
              used_bytes_q[t] = used_bytes_q[t] + c.size;
              active_q[t]    = active_q[t] + 1'b1;
            end
          end
          r.status = hit ? STAT_OK : STAT_NO_SLOT;
        end
        r.count = active_q[t];
        expected_results.push_back(r);
      end
      CMD_FREE: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!hit && slot_state_q[base+i] == SL_ACTIVE && slot_addr_q[base+i] == c.addr) begin
            hit = 1'b1;
            slot_state_q[base+i] = SL_PENDING;
            used_bytes_q[t] = used_bytes_q[t] - slot_size_q[base+i];
            active_q[t]     = active_q[t] - 1'b1;
          end
        end
        r.status = hit ? STAT_OK : STAT_NOTFOUND;
        r.count  = active_q[t];
        expected_results.push_back(r);
      end
      CMD_KILL: begin
        // Killed slots keep their bytes and count; neither kill nor sweep gives them back.
        for (int i = 0; i < SLOTS; i++)
          if (slot_state_q[base+i] == SL_ACTIVE) slot_state_q[base+i] = SL_PENDING;
        r.status = STAT_OK;
        r.count  = active_q[t];
        expected_results.push_back(r);
      end
      default: begin
        // Sweep reports one beat per pending slot, or a single empty beat.
        n_pending = 0;
        for (int i = 0; i < SLOTS; i++)
          if (slot_state_q[base+i] == SL_PENDING) n_pending++;
        r.count = active_q[t];
        if (n_pending == 0) begin
          r.status = STAT_EMPTY;
          expected_results.push_back(r);
        end else begin
          k = 0;
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_state_q[base+i] == SL_PENDING) begin
              slot_state_q[base+i] = SL_RELEASED;
              k++;
              r.status = STAT_OK;
              r.addr   = slot_addr_q[base+i];
              r.size   = slot_size_q[base+i];
              r.last   = (k == n_pending);
              expected_results.push_back(r);
            end
          end
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Compares one result beat with the oldest expectation.
  task automatic check_result(input result_beat_t got);
    result_beat_t want;
    result_count++;
    status_hits[got.status]++;
    if (expected_results.size() == 0) begin
      mismatches++;
      $display("%0t: result beat with nothing expected, expected none, actual %h",
               $time, got);
    end else begin
      want = expected_results.pop_front();
      check_field("status", 32'(want.status), 32'(got.status));
      check_field("block_addr", want.addr, got.addr);
      check_field("block_size", 32'(want.size), 32'(got.size));
      check_field("active_count", 32'(want.count), 32'(got.count));
      check_field("last", 32'(want.last), 32'(got.last));
    end
  endtask

  // Monitor: samples accepted beats at the rising edge and runs the watchdog.
  always @(posedge clk) begin
    in_fired  <= rst_n && in_ch.valid && in_ch.ready;
    out_fired <= rst_n && out_ch.valid && out_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      cmd_count++;
      predict_command({in_ch.cmd, in_ch.task_req, in_ch.req_size, in_ch.req_addr});
    end
    if (rst_n && out_ch.valid && out_ch.ready)
      check_result({out_ch.status, out_ch.block_addr, out_ch.block_size,
                    out_ch.active_count, out_ch.last});
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
      $display("reservation_slot_allocator_core: mismatch");
      $finish;
    end
  end

  // Command driver: presents queued commands at the falling edge with random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fired) begin
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        drv_beat = pending_cmds.pop_front();
        in_ch.cmd      <= drv_beat.cmd;
        in_ch.task_req <= drv_beat.task_id;
        in_ch.req_size <= drv_beat.size;
        in_ch.req_addr <= drv_beat.addr;
        in_ch.valid    <= 1'b1;
        if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result sink: stalls a random number of cycles before each beat.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_fired) begin
        if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
        recv_wait = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // One register write; the shadow follows once the beat is taken.
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_count++;
    if (idx == REG_LIMIT) begin
      limit_q = value[SIZE_W-1:0];
    end else begin
      for (int t = 0; t < TASKS; t++) next_addr_q[t] = value;
    end
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Holds back until every queued command is taken and every result is in.
  task automatic wait_idle();
    while (pending_cmds.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  function automatic cmd_beat_t make_beat(input logic [CMD_W-1:0] cmd, input int t,
                                          input logic [SIZE_W-1:0] size,
                                          input logic [ADDR_W-1:0] addr);
    cmd_beat_t c;
    c.cmd     = cmd;
    c.task_id = TASK_W'(t);
    c.size    = size;
    c.addr    = addr;
    return c;
  endfunction

  // Random commands, generated one at a time so that frees can aim at live blocks.
  task automatic run_random(input int count);
    cmd_beat_t c;
    int        r;
    int        mode;
    int        k;
    int        idx;
    bit        found;
    repeat (count) begin
      while (pending_cmds.size() != 0) @(posedge clk);
      c.task_id = TASK_W'($urandom_range(0, TASKS-1));
      c.addr    = $urandom();
      case ($urandom_range(0, 9))
        0:       c.size = '0;
        1:       c.size = SIZE_W'(4194304);
        2:       c.size = SIZE_W'($urandom_range(0, 32'h3F_FFFF));
        default: c.size = SIZE_W'($urandom_range(1, 32'h3FFF));
      endcase
      r = $urandom_range(0, 99);
      if (r < 40) begin
        c.cmd = CMD_ALLOC;
      end else if (r < 70) begin
        // Mostly a live block of the task, sometimes a stale one, else noise.
        c.cmd = CMD_FREE;
        mode  = $urandom_range(0, 9);
        k     = $urandom_range(0, SLOTS-1);
        found = 1'b0;
        if (mode < 9) begin
          for (int i = 0; i < SLOTS; i++) begin
            idx = int'(c.task_id) * SLOTS + (k + i) % SLOTS;
            if (!found && (mode < 8 ? slot_state_q[idx] == SL_ACTIVE
                                    : slot_state_q[idx] != SL_FREE)) begin
              found  = 1'b1;
              c.addr = slot_addr_q[idx];
            end
          end
        end
      end else if (r < 78) begin
        c.cmd = CMD_KILL;
      end else begin
        c.cmd = CMD_SWEEP;
      end
      pending_cmds.push_back(c);
    end
  endtask

  // Stimulus and end of run.
  initial begin
    in_ch.valid    = 1'b0;
    in_ch.cmd      = CMD_ALLOC;
    in_ch.task_req = '0;
    in_ch.req_size = '0;
    in_ch.req_addr = '0;
    out_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = REG_LIMIT;
    cfg_ch.data    = '0;
    rst_n          = 1'b0;
    limit_q = LIMIT_RST;
    for (int i = 0; i < TASKS*SLOTS; i++) begin
      slot_addr_q[i]  = '0;
      slot_size_q[i]  = '0;
      slot_state_q[i] = SL_FREE;
    end
    for (int t = 0; t < TASKS; t++) begin
      used_bytes_q[t] = '0;
      next_addr_q[t]  = BASE_RST;
      active_q[t]     = '0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Full limit and a base just short of the top, so the bump pointer wraps.
    write_reg(REG_LIMIT, CDATA_W'(LIMIT_RST));
    write_reg(REG_BASE, 32'hFFFF_FFF0);

    // Directed sequence: wrap, zero size, limit first, free miss, kill, sweeps.
    pending_cmds.push_back(make_beat(CMD_ALLOC, 0, 23'd8, '0));
    pending_cmds.push_back(make_beat(CMD_ALLOC, 0, 23'd16, '0));
    pending_cmds.push_back(make_beat(CMD_ALLOC, 0, '0, '0));
    pending_cmds.push_back(make_beat(CMD_ALLOC, 0, SIZE_W'(4194304), '0));
    pending_cmds.push_back(make_beat(CMD_FREE, 0, '0, 32'hFFFF_FFF8));
    pending_cmds.push_back(make_beat(CMD_FREE, 0, '0, 32'h1234_5678));
    pending_cmds.push_back(make_beat(CMD_FREE, 0, '0, 32'hFFFF_FFF8));
    pending_cmds.push_back(make_beat(CMD_KILL, 0, '0, '0));
    pending_cmds.push_back(make_beat(CMD_SWEEP, 0, '0, '0));
    pending_cmds.push_back(make_beat(CMD_SWEEP, 0, '0, '0));
    pending_cmds.push_back(make_beat(CMD_ALLOC, 0, '0, 32'hFFFF_FFFF));
    pending_cmds.push_back(make_beat(CMD_ALLOC, 5, SIZE_W'(4194304), '0));
    pending_cmds.push_back(make_beat(CMD_ALLOC, 5, '0, '0));
    pending_cmds.push_back(make_beat(CMD_ALLOC, 5, 23'd1, '0));
    pending_cmds.push_back(make_beat(CMD_KILL, 5, '0, '0));
    pending_cmds.push_back(make_beat(CMD_ALLOC, 5, 23'd1, '0));
    pending_cmds.push_back(make_beat(CMD_FREE, 5, '0, 32'hFFFF_FFF0));
    pending_cmds.push_back(make_beat(CMD_SWEEP, 5, '0, '0));
    pending_cmds.push_back(make_beat(CMD_SWEEP, 3, '0, '0));
    pending_cmds.push_back(make_beat(CMD_FREE, 3, SIZE_W'(4194304), 32'hFFFF_FFFF));
    pending_cmds.push_back(make_beat(CMD_ALLOC, 7, 23'h3F_FFFF, 32'hFFFF_FFFF));
    pending_cmds.push_back(make_beat(CMD_FREE, 7, SIZE_W'(4194304), 32'hFFFF_FFF0));
    pending_cmds.push_back(make_beat(CMD_SWEEP, 7, '0, '0));
    pending_cmds.push_back(make_beat(CMD_KILL, 2, 23'h3F_FFFF, 32'hFFFF_FFFF));
    wait_idle();

    // Moderate limit and a random base.
    write_reg(REG_LIMIT, CDATA_W'($urandom_range(32'h1_0000, 32'h20_0000)));
    write_reg(REG_BASE, $urandom());
    run_random(160);
    wait_idle();

    // Full limit, base at zero.
    write_reg(REG_LIMIT, CDATA_W'(LIMIT_RST));
    write_reg(REG_BASE, '0);
    run_random(190);
    wait_idle();

    // Zero limit with the tables mostly used up; base at the top.
    write_reg(REG_LIMIT, '0);
    write_reg(REG_BASE, 32'hFFFF_FFFF);
    run_random(50);
    wait_idle();

    // Let any stray beat show up before the verdict.
    repeat (SLOTS + 4) @(posedge clk);
    if (expected_results.size() != 0) begin
      mismatches += expected_results.size();
      $display("%0t: %0d result beats expected, actual none", $time,
               expected_results.size());
    end
    $display("Covered %0d commands, %0d register writes and %0d result beats.",
             cmd_count, cfg_count, result_count);
    $display("Statuses seen: ok %0d, over limit %0d, no slot %0d, not found %0d, empty %0d.",
             status_hits[STAT_OK], status_hits[STAT_OVER], status_hits[STAT_NO_SLOT],
             status_hits[STAT_NOTFOUND], status_hits[STAT_EMPTY]);
    if (mismatches == 0) begin
      $display("reservation_slot_allocator_core: match");
    end else begin
      $display("reservation_slot_allocator_core: mismatch");
    end
    $finish;
  end

endmodule

### filelist.f
design/rsa_pkg.sv
design/rsa_ifs.sv
design/reservation_slot_allocator_core.sv
tb/tb_reservation_slot_allocator_core.sv
